@@ rtl/core/sequence_reorder_window_assert.svh @@
// Assertion macros for the reorder window RTL.
// In synthesis builds the macros expand to nothing.
`ifndef SEQUENCE_REORDER_WINDOW_ASSERT_SVH
`define SEQUENCE_REORDER_WINDOW_ASSERT_SVH
`ifndef SYNTHESIS
// Condition cons must hold in the same cycle as ante.
`define SRW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Condition cons must hold in the cycle after ante.
`define SRW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SRW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SRW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/srw_pkg.sv @@
`default_nettype none
package srw_pkg;

	// Default geometry and the per-item result limit.
	localparam int WINDOW_DEF    = 16;
	localparam int SEQ_SPACE_DEF = 4096;
	localparam int MAX_RESULTS   = 16;
	localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
	localparam int CFG_IDX_W     = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ORDERED_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SINK_CAPACITY = 1'd1;

	typedef enum logic [2:0] {
		ST_DELIVERED = 3'd0,
		ST_BUFFERED  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_OUTSIDE   = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef struct packed {
		logic [31:0] seq_number;
		logic [31:0] byte_offset;
		logic [15:0] byte_length;
		logic        has_payload;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic        write_enable;
		logic [31:0] write_offset;
		logic [15:0] write_length;
		logic        delivered_valid;
		logic [31:0] delivered_seq;
		logic [31:0] delivered_total;
		logic        last;
	} result_t;

	// Flags returned by the shared subtractor.
	typedef struct packed {
		logic [31:0] diff;
		logic        borrow;
		logic        zero;
	} sub_res_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CAP,
		S_LEN,
		S_REL,
		S_DEC,
		S_SCMP,
		S_DRD,
		S_DCMP,
		S_EMIT
	} state_t;

endpackage
`default_nettype wire

@@ rtl/core/srw_sub.sv @@
`default_nettype none
module srw_sub (
	input  wire logic [31:0]      a,
	input  wire logic [31:0]      b,
	output srw_pkg::sub_res_t     res
);
	import srw_pkg::*;

	logic [32:0] wide;

	// One 32-bit subtract serves the sink bound, sequence and slot tag checks.
	always_comb begin
		wide       = {1'b0, a} - {1'b0, b};
		res.diff   = wide[31:0];
		res.borrow = wide[32];
		res.zero   = (wide[31:0] == 32'd0);
	end

endmodule
`default_nettype wire

@@ rtl/core/sequence_reorder_window.sv @@
// Flow: the single shared subtractor steps an item through S_CAP, S_LEN and
// S_REL, then S_DEC decides, a slot may be read and compared (S_SCMP, or S_DRD
// and S_DCMP) and S_EMIT registers the result; each drained slot repeats S_DRD,
// S_DCMP and S_EMIT. A new item is taken only back in S_IDLE, after that.
// Reset: all control clears at once, then the seen map is swept to zero with
// the item input stalled; configuration writes are taken.
`default_nettype none
`include "sequence_reorder_window_assert.svh"
module sequence_reorder_window #(
	parameter int WINDOW    = srw_pkg::WINDOW_DEF,
	parameter int SEQ_SPACE = srw_pkg::SEQ_SPACE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire srw_pkg::item_t                item,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output srw_pkg::result_t                   result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [srw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data
);
	import srw_pkg::*;

	localparam int SLW = $clog2(WINDOW);
	localparam int SW  = $clog2(SEQ_SPACE);
	localparam logic [SLW:0]    WIN_W     = (SLW + 1)'(WINDOW);
	localparam logic [SLW-1:0]  SLOT_LAST = SLW'(WINDOW - 1);
	localparam logic [31:0]     WIN_32    = 32'(WINDOW);
	localparam logic [31:0]     SPACE_32  = 32'(SEQ_SPACE);
	localparam logic [SW-1:0]   SEEN_LAST = SW'(SEQ_SPACE - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);

	state_t state_q, state_d;

	// Configuration.
	logic        ordered_q;
	logic [31:0] cap_q;

	// Item under work and its check results.
	item_t       item_q;
	logic [31:0] cap_off_q;
	logic        off_gt_q;
	logic        we_q;
	logic [31:0] rel_q;
	logic        late_q;
	logic        exact_q;
	logic [SLW-1:0] slot_q;

	// Window state.
	logic [31:0]     ne_q;
	logic [SLW-1:0]  ne_slot_q;
	logic [31:0]     dc_q;
	logic [WINDOW-1:0] slot_valid_q;
	logic [31:0]     slot_mem [WINDOW];
	logic [31:0]     slot_rd_q;
	logic            seen_mem [SEQ_SPACE];
	logic            seen_rd_q;
	logic [SW-1:0]   clr_q;

	// Drain bookkeeping and output staging.
	logic [CNT_W-1:0] cnt_q;
	logic             match_q;
	result_t          pend_q;
	result_t          result_q;
	logic             result_valid_q;

	// Combinational control.
	logic [31:0]    alu_a, alu_b;
	sub_res_t       alu;
	logic           seen_re, seen_we, seen_wd;
	logic [SW-1:0]  seen_ra, seen_wa;
	logic           slot_re, slot_we;
	logic [SLW-1:0] slot_ra;
	logic           stall_c;
	logic           emit_ok;
	logic           oor;
	logic           in_window;
	logic [SLW:0]   slot_sum;
	logic [SLW-1:0] slot_calc;
	logic [SLW-1:0] ne_slot_inc;
	logic           dup_s;
	logic           d_match;
	result_t        fail_res, range_res, dup_res, outside_res;
	result_t        hit_res, buf_res, drain_res, emit_res;

	srw_sub u_sub (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu)
	);

	// Decode helpers derived from stored state.
	always_comb begin
		emit_ok     = !result_valid_q || !result_stall;
		oor         = (item_q.seq_number >= SPACE_32);
		in_window   = !late_q && !exact_q && (rel_q < WIN_32);
		slot_sum    = {1'b0, ne_slot_q} + {1'b0, rel_q[SLW-1:0]};
		slot_calc   = (slot_sum >= WIN_W) ? SLW'(slot_sum - WIN_W) : slot_sum[SLW-1:0];
		ne_slot_inc = (ne_slot_q == SLOT_LAST) ? '0 : ne_slot_q + SLW'(1);
		dup_s       = slot_valid_q[slot_q] && alu.zero;
		d_match     = slot_valid_q[ne_slot_q] && alu.zero && (cnt_q < CNT_MAX);
	end

	// Candidate results for the decision states.
	always_comb begin
		fail_res                 = '0;
		fail_res.delivered_total = dc_q;

		range_res                = fail_res;
		range_res.status         = ST_RANGE;
		dup_res                  = fail_res;
		dup_res.status           = ST_DUPLICATE;
		outside_res              = fail_res;
		outside_res.status       = ST_OUTSIDE;

		hit_res                  = '0;
		hit_res.status           = ST_DELIVERED;
		hit_res.write_enable     = we_q;
		hit_res.write_offset     = we_q ? item_q.byte_offset : 32'd0;
		hit_res.write_length     = we_q ? item_q.byte_length : 16'd0;
		hit_res.delivered_valid  = 1'b1;
		hit_res.delivered_seq    = item_q.seq_number;
		hit_res.delivered_total  = dc_q + 32'd1;

		buf_res                  = hit_res;
		buf_res.status           = ST_BUFFERED;
		buf_res.delivered_valid  = 1'b0;
		buf_res.delivered_seq    = 32'd0;
		buf_res.delivered_total  = dc_q;

		drain_res                 = '0;
		drain_res.status          = ST_DELIVERED;
		drain_res.delivered_valid = 1'b1;
		drain_res.delivered_seq   = ne_q;
		drain_res.delivered_total = dc_q + 32'd1;

		// The staged result is the last one of its item unless a drain follows.
		emit_res      = pend_q;
		emit_res.last = !match_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == SEEN_LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (item_valid) state_d = S_CAP;
			end
			S_CAP:  state_d = S_LEN;
			S_LEN:  state_d = S_REL;
			S_REL:  state_d = S_DEC;
			S_DEC: begin
				if (ordered_q && exact_q) state_d = S_DRD;
				else if (ordered_q && in_window) state_d = S_SCMP;
				else state_d = S_EMIT;
			end
			S_SCMP: state_d = S_EMIT;
			S_DRD:  state_d = S_DCMP;
			S_DCMP: state_d = S_EMIT;
			S_EMIT: begin
				if (emit_ok) state_d = match_q ? S_DRD : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Per-state datapath control: subtractor operands and memory ports.
	always_comb begin
		alu_a   = 32'd0;
		alu_b   = 32'd0;
		stall_c = 1'b1;
		seen_re = 1'b0;
		seen_ra = item.seq_number[SW-1:0];
		seen_we = 1'b0;
		seen_wa = item_q.seq_number[SW-1:0];
		seen_wd = 1'b1;
		slot_re = 1'b0;
		slot_ra = ne_slot_q;
		slot_we = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				seen_we = 1'b1;
				seen_wa = clr_q;
				seen_wd = 1'b0;
			end
			S_IDLE: begin
				stall_c = 1'b0;
				seen_re = item_valid;
			end
			S_CAP: begin
				alu_a = cap_q;
				alu_b = item_q.byte_offset;
			end
			S_LEN: begin
				alu_a = cap_off_q;
				alu_b = {16'd0, item_q.byte_length};
			end
			S_REL: begin
				alu_a = item_q.seq_number;
				alu_b = ne_q;
			end
			S_DEC: begin
				seen_we = !ordered_q && !oor && !seen_rd_q;
				slot_re = ordered_q && in_window;
				slot_ra = slot_calc;
			end
			S_SCMP: begin
				alu_a   = slot_rd_q;
				alu_b   = item_q.seq_number;
				slot_we = !dup_s;
			end
			S_DRD: begin
				slot_re = 1'b1;
			end
			S_DCMP: begin
				alu_a = slot_rd_q;
				alu_b = ne_q;
			end
			S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Seen map memory, swept to zero after reset.
	always_ff @(posedge clk) begin
		if (seen_we) seen_mem[seen_wa] <= seen_wd;
		if (seen_re) seen_rd_q <= seen_mem[seen_ra];
	end

	// Slot sequence memory.
	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_q] <= item_q.seq_number;
		if (slot_re) slot_rd_q <= slot_mem[slot_ra];
	end

	// Control state, counters and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			ordered_q      <= 1'b0;
			cap_q          <= 32'd0;
			clr_q          <= '0;
			ne_q           <= 32'd0;
			ne_slot_q      <= '0;
			dc_q           <= 32'd0;
			slot_valid_q   <= '0;
			cnt_q          <= '0;
			match_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid) begin
				priority if (cfg_index == CFG_ORDERED_MODE) begin
					ordered_q <= cfg_data[0];
				end else if (cfg_index == CFG_SINK_CAPACITY) begin
					cap_q <= cfg_data;
				end
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SW'(1);
				end
				S_DEC: begin
					match_q <= 1'b0;
					if (!ordered_q) begin
						if (!oor && !seen_rd_q) dc_q <= dc_q + 32'd1;
					end else if (exact_q) begin
						dc_q      <= dc_q + 32'd1;
						ne_q      <= ne_q + 32'd1;
						ne_slot_q <= ne_slot_inc;
						cnt_q     <= CNT_W'(1);
					end
				end
				S_SCMP: begin
					if (!dup_s) slot_valid_q[slot_q] <= 1'b1;
				end
				S_DCMP: begin
					match_q <= d_match;
				end
				S_EMIT: begin
					if (emit_ok && match_q) begin
						slot_valid_q[ne_slot_q] <= 1'b0;
						dc_q      <= dc_q + 32'd1;
						ne_q      <= ne_q + 32'd1;
						ne_slot_q <= ne_slot_inc;
						cnt_q     <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase

			if (state_q == S_EMIT && emit_ok) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	// Item payload, check results and result staging.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) item_q <= item;
			end
			S_CAP: begin
				cap_off_q <= alu.diff;
				off_gt_q  <= alu.borrow;
			end
			S_LEN: begin
				we_q <= (cap_q != 32'd0) && item_q.has_payload &&
					(item_q.byte_length != 16'd0) && !off_gt_q && !alu.borrow;
			end
			S_REL: begin
				rel_q   <= alu.diff;
				late_q  <= alu.borrow;
				exact_q <= alu.zero;
			end
			S_DEC: begin
				slot_q <= slot_calc;
				if (!ordered_q) begin
					if (oor) begin
						pend_q <= range_res;
					end else if (seen_rd_q) begin
						pend_q <= dup_res;
					end else begin
						pend_q <= hit_res;
					end
				end else if (late_q) begin
					pend_q <= dup_res;
				end else if (exact_q) begin
					pend_q <= hit_res;
				end else if (!in_window) begin
					pend_q <= outside_res;
				end
			end
			S_SCMP: begin
				if (dup_s) begin
					pend_q <= dup_res;
				end else begin
					pend_q <= buf_res;
				end
			end
			S_EMIT: begin
				if (emit_ok) begin
					result_q <= emit_res;
					if (match_q) pend_q <= drain_res;
				end
			end
			default: begin
			end
		endcase
	end

	assign item_stall   = stall_c;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	// An accepted item always starts the check sequence.
	`SRW_ASSERT_NXT(a_accept_starts, clk, arst_n, item_valid && !item_stall, state_q == S_CAP, "accepted item did not start checks")
	// The drain never runs past the per-item result limit.
	`SRW_ASSERT_IMP(a_drain_bound, clk, arst_n, state_q == S_DCMP, cnt_q <= CNT_MAX, "drain exceeded result limit")
	// A staged delivery carries the delivered count that goes with it.
	`SRW_ASSERT_IMP(a_total_match, clk, arst_n, state_q == S_EMIT && pend_q.delivered_valid, pend_q.delivered_total == dc_q, "delivered total out of step")

endmodule
`default_nettype wire

@@ verif/sequence_reorder_window_test.sv @@
`timescale 1ns / 1ps
module sequence_reorder_window_test;
	import srw_pkg::*;

	localparam int WIN     = WINDOW_DEF;
	localparam int SPACE   = SEQ_SPACE_DEF;
	localparam int SINK_4K = 4096;

	// Predicted block state, configuration included.
	typedef struct {
		bit        ordered;
		bit [31:0] capacity;
		bit [31:0] next_seq;
		bit [31:0] total;
		bit        slot_used [WIN];
		bit [31:0] slot_tag [WIN];
		bit        seen [SPACE];
	} window_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Checker state follows accepted items; the generator copy runs ahead of it.
	window_t model_st;
	window_t gen_st;
	item_t pending_items[$];
	result_t expected_results[$];
	result_t gen_scratch[$];
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int mismatch_count = 0;
	int results_checked = 0;
	int items_accepted = 0;
	int longest_burst = 0;

	sequence_reorder_window dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d field %s is %h, expected %h",
				results_checked, field, got, want));
	endtask

	function automatic void add_result(inout result_t q[$], input status_t code,
			input bit wr, input bit [31:0] off, input bit [15:0] len, input bit dv,
			input bit [31:0] dseq, input bit [31:0] total);
		result_t r;
		r.status = code;
		r.write_enable = wr;
		r.write_offset = wr ? off : 32'd0;
		r.write_length = wr ? len : 16'd0;
		r.delivered_valid = dv;
		r.delivered_seq = dv ? dseq : 32'd0;
		r.delivered_total = total;
		r.last = 1'b0;
		q = {q, r};
	endfunction

	// Works out the results of one item and advances the given state.
	function automatic void predict_window(inout window_t st, input item_t it,
			inout result_t q[$]);
		bit wr;
		bit [31:0] seq;
		bit [31:0] rel;
		int s;
		int n;
		seq = it.seq_number;
		wr = st.capacity != 0 && it.has_payload && it.byte_length != 0
			&& it.byte_offset <= st.capacity
			&& {16'd0, it.byte_length} <= st.capacity - it.byte_offset;
		if (!st.ordered) begin
			if (seq >= SPACE) begin
				add_result(q, ST_RANGE, 0, 0, 0, 0, 0, st.total);
			end else if (st.seen[seq]) begin
				add_result(q, ST_DUPLICATE, 0, 0, 0, 0, 0, st.total);
			end else begin
				st.seen[seq] = 1'b1;
				st.total++;
				add_result(q, ST_DELIVERED, wr, it.byte_offset, it.byte_length, 1, seq,
					st.total);
			end
		end else if (seq < st.next_seq) begin
			add_result(q, ST_DUPLICATE, 0, 0, 0, 0, 0, st.total);
		end else if (seq > st.next_seq) begin
			rel = seq - st.next_seq;
			s = int'(seq % WIN);
			if (rel >= WIN) begin
				add_result(q, ST_OUTSIDE, 0, 0, 0, 0, 0, st.total);
			end else if (st.slot_used[s] && st.slot_tag[s] == seq) begin
				add_result(q, ST_DUPLICATE, 0, 0, 0, 0, 0, st.total);
			end else begin
				st.slot_used[s] = 1'b1;
				st.slot_tag[s] = seq;
				add_result(q, ST_BUFFERED, wr, it.byte_offset, it.byte_length, 0, 0,
					st.total);
			end
		end else begin
			st.total++;
			st.next_seq++;
			add_result(q, ST_DELIVERED, wr, it.byte_offset, it.byte_length, 1, seq,
				st.total);
			n = 1;
			s = int'(st.next_seq % WIN);
			// Drain the run of marked slots that now follows in order.
			while (n < MAX_RESULTS && st.slot_used[s] && st.slot_tag[s] == st.next_seq) begin
				st.slot_used[s] = 1'b0;
				st.total++;
				add_result(q, ST_DELIVERED, 0, 0, 0, 1, st.next_seq, st.total);
				st.next_seq++;
				n++;
				s = int'(st.next_seq % WIN);
			end
		end
		q[q.size() - 1].last = 1'b1;
	endfunction

	// Item driver: a stalled item holds, otherwise the next one goes out or the line idles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				int prior_size;
				prior_size = expected_results.size();
				predict_window(model_st, item, expected_results);
				items_accepted++;
				if (expected_results.size() - prior_size > longest_burst)
					longest_burst = expected_results.size() - prior_size;
			end
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %h arrived with none expected", result));
				end else begin
					want = expected_results.pop_front();
					check_field("status", result.status, want.status);
					check_field("write_enable", result.write_enable, want.write_enable);
					check_field("write_offset", result.write_offset, want.write_offset);
					check_field("write_length", result.write_length, want.write_length);
					check_field("delivered_valid", result.delivered_valid,
						want.delivered_valid);
					check_field("delivered_seq", result.delivered_seq, want.delivered_seq);
					check_field("delivered_total", result.delivered_total,
						want.delivered_total);
					check_field("last", result.last, want.last);
				end
				results_checked++;
			end
			result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ORDERED_MODE)
			model_st.ordered = value[0];
		else if (idx == CFG_SINK_CAPACITY)
			model_st.capacity = value;
		gen_st = model_st;
	endtask

	task automatic queue_item(input item_t it);
		pending_items = {pending_items, it};
		predict_window(gen_st, it, gen_scratch);
		gen_scratch.delete();
	endtask

	function automatic item_t make_item(input logic [31:0] seq, input logic [31:0] off,
			input logic [15:0] len, input logic pay);
		item_t it;
		it.seq_number = seq;
		it.byte_offset = off;
		it.byte_length = len;
		it.has_payload = pay;
		return it;
	endfunction

	// Byte fields aimed mostly at the sink bounds, with the rest fully random.
	function automatic item_t random_item(input logic [31:0] seq);
		item_t it;
		logic [31:0] room;
		it.seq_number = seq;
		it.has_payload = ($urandom_range(0, 7) != 0);
		it.byte_length = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 16'hFFFF))
			: 16'($urandom_range(0, 64));
		if (gen_st.capacity != 0 && $urandom_range(0, 3) != 0) begin
			it.byte_offset = $urandom_range(0, gen_st.capacity);
			room = gen_st.capacity - it.byte_offset;
			// Land exactly on the end of the sink now and then.
			if (room <= 32'hFFFF && $urandom_range(0, 2) == 0)
				it.byte_length = room[15:0];
		end else begin
			it.byte_offset = $urandom;
		end
		return it;
	endfunction

	task automatic gen_unordered(input int count);
		logic [31:0] seq;
		int i;
		int roll;
		for (i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 65)
				seq = $urandom_range(0, SPACE - 1);
			else if (roll < 85)
				seq = $urandom_range(0, 63);
			else if (roll < 92)
				seq = $urandom_range(SPACE, SPACE + 8);
			else
				seq = $urandom_range(SPACE, 32'hFFFF_FFFF);
			queue_item(random_item(seq));
		end
	endtask

	// Mostly shuffled runs starting at the next expected number, sometimes with a
	// block missing; the rest is late, far-ahead, in-window early or random numbers.
	task automatic gen_ordered(input int count);
		logic [31:0] run[$];
		logic [31:0] base;
		logic [31:0] tmp;
		int added;
		int k;
		int i;
		int pick;
		added = 0;
		while (added < count) begin
			base = gen_st.next_seq;
			if ($urandom_range(0, 99) < 80) begin
				k = $urandom_range(1, WIN);
				run.delete();
				for (i = 0; i < k; i++)
					run = {run, 32'(base + i)};
				for (i = k - 1; i > 0; i--) begin
					pick = $urandom_range(0, i);
					tmp = run[i];
					run[i] = run[pick];
					run[pick] = tmp;
				end
				if (k > 1 && $urandom_range(0, 9) == 0)
					run.delete($urandom_range(0, k - 1));
				for (i = 0; i < run.size(); i++) begin
					queue_item(random_item(run[i]));
					added++;
				end
			end else begin
				case ($urandom_range(0, 3))
					0: tmp = (base == 0) ? $urandom
						: base - $urandom_range(1, (base < 40) ? base : 40);
					1: tmp = base + WIN + $urandom_range(0, 40);
					2: tmp = base + $urandom_range(1, WIN - 1);
					default: tmp = $urandom;
				endcase
				queue_item(random_item(tmp));
				added++;
			end
		end
	endtask

	// The block is idle once every item is in and every result is out.
	task automatic wait_quiet();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (8) @(negedge clk);
		gen_st = model_st;
	endtask

	initial begin
		int s;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Unordered mode against a 4 KiB sink: write bounds, repeats, range check.
		tx_idle_pct = 31;
		rx_idle_pct = 69;
		write_reg(CFG_ORDERED_MODE, 32'd0);
		write_reg(CFG_SINK_CAPACITY, SINK_4K);
		queue_item(make_item(0, SINK_4K - 16, 16, 1'b1));
		queue_item(make_item(0, 0, 1, 1'b1));
		queue_item(make_item(SPACE - 1, SINK_4K, 0, 1'b1));
		queue_item(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
		queue_item(make_item(8, SINK_4K - 15, 16, 1'b1));
		queue_item(make_item(9, SINK_4K + 904, 1, 1'b1));
		queue_item(make_item(10, 0, 10, 1'b0));
		gen_unordered(40);
		wait_quiet();

		// Ordered mode with the largest sink: late, outside the window, marked
		// twice, then the expected block releasing the fifteen marked slots.
		write_reg(CFG_ORDERED_MODE, 32'd1);
		write_reg(CFG_SINK_CAPACITY, 32'hFFFF_FFFF);
		queue_item(make_item(0, 0, 16'hFFFF, 1'b1));
		queue_item(make_item(0, 0, 16'hFFFF, 1'b1));
		queue_item(make_item(WIN + 1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
		for (s = WIN; s >= 2; s--)
			queue_item(make_item(s, 32'hFFFF_FFFF - s, 16'(s), 1'b1));
		queue_item(make_item(2, 0, 1, 1'b1));
		queue_item(make_item(1, 32'hFFFF_FFFF, 0, 1'b0));
		gen_ordered(50);
		wait_quiet();

		// Swap the idle pattern; no sink, then unordered with a random sink.
		tx_idle_pct = 69;
		rx_idle_pct = 31;
		write_reg(CFG_SINK_CAPACITY, 32'd0);
		gen_ordered(40);
		wait_quiet();
		write_reg(CFG_ORDERED_MODE, 32'd0);
		write_reg(CFG_SINK_CAPACITY, $urandom);
		gen_unordered(30);
		wait_quiet();

		// Full rate on both sides, switching modes with state kept in each.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(CFG_ORDERED_MODE, 32'd1);
		write_reg(CFG_SINK_CAPACITY, $urandom_range(1, 1 << 20));
		gen_ordered(35);
		wait_quiet();
		write_reg(CFG_ORDERED_MODE, 32'd0);
		gen_unordered(20);
		wait_quiet();
		write_reg(CFG_ORDERED_MODE, 32'd1);
		gen_ordered(20);
		wait_quiet();
		repeat (60) @(posedge clk);

		$display("Ran %0d items through unordered and ordered modes, sinks from none to full.",
			items_accepted);
		$display("Checked %0d results; the longest burst from one item was %0d.",
			results_checked, longest_burst);
		if (mismatch_count == 0) begin
			$display("sequence_reorder_window regression: pass");
		end else begin
			$display("sequence_reorder_window regression: fail");
		end
		$finish;
	end

	// Guard against a hang: far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("sequence_reorder_window regression: fail");
		$finish;
	end

endmodule
